// ----- rtl/cnp_pkg.sv -----
package cnp_pkg;

    // Width kept for namesize and filesize (16..32).
    localparam int LEN_W = 32;

    localparam int HDR_BYTES    = 110;
    localparam int MAGIC_BYTES  = 6;
    localparam int FIELD_DIGITS = 8;
    localparam int DEC_FIELDS   = 12;
    localparam int TRL_LEN      = 11;

    localparam logic [3:0] FID_FILESIZE = 4'd6;
    localparam logic [3:0] FID_NAMESIZE = 4'd11;

    localparam logic [2:0] KIND_MAGIC    = 3'd0;
    localparam logic [2:0] KIND_HEX      = 3'd1;
    localparam logic [2:0] KIND_CHECK    = 3'd2;
    localparam logic [2:0] KIND_NAME     = 3'd3;
    localparam logic [2:0] KIND_NAME_PAD = 3'd4;
    localparam logic [2:0] KIND_DATA     = 3'd5;
    localparam logic [2:0] KIND_DATA_PAD = 3'd6;
    localparam logic [2:0] KIND_AFTER    = 3'd7;

    localparam int TDATA_OUT_W = 56;

    typedef struct packed {
        logic       step;
        logic       first;
        logic       last;
        logic [3:0] fid;
    } t_field_ctl;

    typedef struct packed {
        logic        done;
        logic [3:0]  id;
        logic [31:0] value;
        logic        bad;
    } t_field_res;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  echo;
        logic        field_done;
        logic [3:0]  field_id;
        logic [31:0] field_value;
        logic        bad_digit;
        logic        entry_end;
        logic        trailer_seen;
    } t_result;

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "T";
            4'd1:    c = "R";
            4'd2:    c = "A";
            4'd3:    c = "I";
            4'd4:    c = "L";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "!";
            4'd8:    c = "!";
            4'd9:    c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/cnp_hex_field.sv -----
module cnp_hex_field (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cnp_pkg::t_field_ctl i_ctl,
    input  logic [7:0]          i_byte,
    output cnp_pkg::t_field_res o_res
);

    logic [31:0] r_acc;
    logic        r_stopped;
    logic [31:0] n_acc;
    logic        n_stopped;
    logic [31:0] acc_base;
    logic        stop_base;
    logic        dig_ok;
    logic [3:0]  dig_val;

    always_comb begin
        dig_ok  = 1'b1;
        dig_val = 4'd0;
        if (i_byte >= "0" && i_byte <= "9") begin
            dig_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= "a" && i_byte <= "f") begin
            dig_val = 4'(i_byte - 8'h57);
        end else if (i_byte >= "A" && i_byte <= "F") begin
            dig_val = 4'(i_byte - 8'h37);
        end else begin
            dig_ok = 1'b0;
        end
    end

    always_comb begin
        acc_base  = i_ctl.first ? 32'd0 : r_acc;
        stop_base = i_ctl.first ? 1'b0 : r_stopped;
        n_acc     = acc_base;
        n_stopped = stop_base;
        // first non-hex char freezes the field
        if (!stop_base) begin
            if (dig_ok) begin
                n_acc = {acc_base[27:0], dig_val};
            end else begin
                n_stopped = 1'b1;
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (i_ctl.last) begin
            o_res.done  = 1'b1;
            o_res.id    = i_ctl.fid;
            o_res.value = n_acc;
            o_res.bad   = n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_stopped <= 1'b0;
        end else if (i_ctl.step) begin
            r_acc     <= n_acc;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ----- rtl/cnp_walk.sv -----
module cnp_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  cnp_pkg::t_field_res i_field,
    output cnp_pkg::t_field_ctl o_fctl,
    output cnp_pkg::t_result    o_res
);

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_NAME     = 3'd1;
    localparam logic [2:0] PH_NAME_PAD = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_DATA_PAD = 3'd4;
    localparam logic [2:0] PH_DONE     = 3'd5;

    localparam logic [6:0] HO_FIELD_LO = 7'(cnp_pkg::MAGIC_BYTES);
    localparam logic [6:0] HO_FIELD_HI =
        7'(cnp_pkg::MAGIC_BYTES + cnp_pkg::DEC_FIELDS * cnp_pkg::FIELD_DIGITS);
    localparam logic [6:0] HO_LAST     = 7'(cnp_pkg::HDR_BYTES - 1);
    localparam logic [3:0] TRL_IDX     = 4'(cnp_pkg::TRL_LEN);
    localparam logic [cnp_pkg::LEN_W-1:0] TRL_NAMESIZE = cnp_pkg::LEN_W'(cnp_pkg::TRL_LEN);
    localparam logic [cnp_pkg::LEN_W-1:0] LEN_ONE      = cnp_pkg::LEN_W'(1);

    logic [2:0]               r_phase,    n_phase;
    logic [6:0]               r_ho,       n_ho;
    logic [cnp_pkg::LEN_W-1:0] r_name_len, n_name_len;
    logic [cnp_pkg::LEN_W-1:0] r_data_len, n_data_len;
    logic [cnp_pkg::LEN_W-1:0] r_left,     n_left;
    logic [1:0]               r_off,      n_off;
    logic                     r_tmatch,   n_tmatch;
    logic [3:0]               r_name_idx, n_name_idx;

    logic [6:0] rel;
    logic       in_field;
    logic       match_now;

    assign rel      = r_ho - HO_FIELD_LO;
    assign in_field = (r_phase == PH_HEADER) && (r_ho >= HO_FIELD_LO) && (r_ho < HO_FIELD_HI);

    always_comb begin
        o_fctl.step  = i_step && in_field;
        o_fctl.first = rel[2:0] == 3'd0;
        o_fctl.last  = in_field && (rel[2:0] == 3'd7);
        o_fctl.fid   = rel[6:3];
    end

    assign match_now = r_tmatch && (r_name_idx < TRL_IDX)
                       && (i_byte == cnp_pkg::trailer_char(r_name_idx));

    always_comb begin
        n_phase    = r_phase;
        n_ho       = r_ho;
        n_name_len = r_name_len;
        n_data_len = r_data_len;
        n_left     = r_left;
        n_off      = r_off + 2'd1;
        n_tmatch   = r_tmatch;
        n_name_idx = r_name_idx;

        o_res              = '0;
        o_res.kind         = cnp_pkg::KIND_AFTER;
        o_res.echo         = i_byte;
        o_res.field_done   = i_field.done;
        o_res.field_id     = i_field.id;
        o_res.field_value  = i_field.value;
        o_res.bad_digit    = i_field.bad;

        case (r_phase)
            PH_HEADER: begin
                if (r_ho < HO_FIELD_LO) begin
                    o_res.kind = cnp_pkg::KIND_MAGIC;
                end else if (r_ho < HO_FIELD_HI) begin
                    o_res.kind = cnp_pkg::KIND_HEX;
                    if (i_field.done && i_field.id == cnp_pkg::FID_FILESIZE) begin
                        n_data_len = i_field.value[cnp_pkg::LEN_W-1:0];
                    end
                    if (i_field.done && i_field.id == cnp_pkg::FID_NAMESIZE) begin
                        n_name_len = i_field.value[cnp_pkg::LEN_W-1:0];
                    end
                end else begin
                    o_res.kind = cnp_pkg::KIND_CHECK;
                end
                if (r_ho == HO_LAST) begin
                    n_ho       = '0;
                    n_tmatch   = 1'b1;
                    n_name_idx = '0;
                    n_left     = r_name_len;
                    if (r_name_len != '0) begin
                        n_phase = PH_NAME;
                    end else if (n_off != 2'd0) begin
                        n_phase = PH_NAME_PAD;
                    end else if (r_data_len != '0) begin
                        n_phase = PH_DATA;
                        n_left  = r_data_len;
                    end else begin
                        n_phase         = PH_HEADER;
                        o_res.entry_end = 1'b1;
                    end
                end else begin
                    n_ho = r_ho + 7'd1;
                end
            end
            PH_NAME: begin
                o_res.kind = cnp_pkg::KIND_NAME;
                n_tmatch   = match_now;
                n_left     = r_left - LEN_ONE;
                if (r_name_idx < TRL_IDX) begin
                    n_name_idx = r_name_idx + 4'd1;
                end
                if (r_left == LEN_ONE) begin
                    if (match_now && r_name_len == TRL_NAMESIZE) begin
                        o_res.trailer_seen = 1'b1;
                        n_phase            = PH_DONE;
                    end else if (n_off != 2'd0) begin
                        n_phase = PH_NAME_PAD;
                    end else if (r_data_len != '0) begin
                        n_phase = PH_DATA;
                        n_left  = r_data_len;
                    end else begin
                        n_phase         = PH_HEADER;
                        o_res.entry_end = 1'b1;
                    end
                end
            end
            PH_NAME_PAD: begin
                o_res.kind = cnp_pkg::KIND_NAME_PAD;
                if (n_off == 2'd0) begin
                    if (r_data_len != '0) begin
                        n_phase = PH_DATA;
                        n_left  = r_data_len;
                    end else begin
                        n_phase         = PH_HEADER;
                        o_res.entry_end = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                o_res.kind = cnp_pkg::KIND_DATA;
                n_left     = r_left - LEN_ONE;
                if (r_left == LEN_ONE) begin
                    if (n_off != 2'd0) begin
                        n_phase = PH_DATA_PAD;
                    end else begin
                        n_phase         = PH_HEADER;
                        o_res.entry_end = 1'b1;
                    end
                end
            end
            PH_DATA_PAD: begin
                o_res.kind = cnp_pkg::KIND_DATA_PAD;
                if (n_off == 2'd0) begin
                    n_phase         = PH_HEADER;
                    o_res.entry_end = 1'b1;
                end
            end
            default: begin
                o_res.kind = cnp_pkg::KIND_AFTER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_ho       <= '0;
            r_name_len <= '0;
            r_data_len <= '0;
            r_left     <= '0;
            r_off      <= '0;
            r_tmatch   <= 1'b1;
            r_name_idx <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_ho       <= n_ho;
            r_name_len <= n_name_len;
            r_data_len <= n_data_len;
            r_left     <= n_left;
            r_off      <= n_off;
            r_tmatch   <= n_tmatch;
            r_name_idx <= n_name_idx;
        end
    end

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |=> r_phase == PH_DONE)
        else $error("walk left the after-trailer phase");

    a_name_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_NAME |-> r_left != '0)
        else $error("name phase with no bytes left");

    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != '0)
        else $error("data phase with no bytes left");

    a_ho_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ho <= HO_LAST)
        else $error("header offset past header end");

    a_ho_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEADER |-> r_ho == '0)
        else $error("header offset nonzero outside header");

endmodule

// ----- rtl/cpio_newc_stream_parser.sv -----
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  archive byte
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  per-byte classification + field result
//
// One result per input byte, one byte per clock sustained while i_m_axis_tready stays high.
// Each byte passes through the input register, then is decoded into the output register.
// The walk state advances when a byte moves from the input to the output register.
// A stalled output holds its result; the input register takes one more byte if empty, then holds it.
// Synchronous active-low reset returns the walker to the start of a header.
module cpio_newc_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] archive_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] byte_kind, [10:3] byte_echo, [11] field_done, [15:12] field_id,
    // [47:16] field_value, [48] bad_digit, [49] entry_end, [50] trailer_seen
    output logic [cnp_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    cnp_pkg::t_result r_out;

    logic                advance;
    cnp_pkg::t_field_ctl fctl;
    cnp_pkg::t_field_res fres;
    cnp_pkg::t_result    res;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    cnp_hex_field u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fctl),
        .i_byte  (r_in_byte),
        .o_res   (fres)
    );

    cnp_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_field (fres),
        .o_fctl  (fctl),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0,
                              r_out.trailer_seen,
                              r_out.entry_end,
                              r_out.bad_digit,
                              r_out.field_value,
                              r_out.field_id,
                              r_out.field_done,
                              r_out.echo,
                              r_out.kind};

endmodule
